@@ design/wsp_pkg.sv @@
package wsp_pkg;

  // field and datapath widths
  localparam int CoordW   = 8;
  localparam int AngleW   = 8;
  localparam int ZoomW    = 8;
  localparam int TrigW    = 9;   // sine and cosine, -128..128
  localparam int ProdW    = 20;  // products and sums before the /128
  localparam int RotW     = 11;  // rotated coordinates
  localparam int DepthW   = 12;  // offset depth
  localparam int NumW     = 16;  // magnitude of coordinate times zoom
  localparam int DivW     = 9;   // divisor, 30..511
  localparam int RemW     = DivW;
  localparam int PosW     = 18;  // screen position before range check
  localparam int ScreenW  = 8;

  localparam int Points        = 2;
  localparam int Lanes         = 2 * Points;  // u and v of each endpoint
  localparam int DivStages     = 4;
  localparam int BitsPerStage  = NumW / DivStages;

  localparam int AddrW = 4;
  localparam int DataW = 32;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] RegYaw   = 2'd0;
  localparam logic [1:0] RegPitch = 2'd1;
  localparam logic [1:0] RegZoom  = 2'd2;

  localparam logic [AngleW-1:0] YawReset   = 8'd22;
  localparam logic [AngleW-1:0] PitchReset = 8'd12;
  localparam logic [ZoomW-1:0]  ZoomReset  = 8'd128;

  localparam logic signed [DepthW-1:0] DepthOffset = 12'sd190;
  localparam logic signed [DepthW-1:0] DepthMin    = 12'sd30;
  localparam logic signed [PosW-1:0]   ColCentre   = 18'sd128;
  localparam logic signed [PosW-1:0]   RowCentre   = 18'sd100;
  localparam logic signed [PosW-1:0]   ColMin      = 18'sd0;
  localparam logic signed [PosW-1:0]   ColMax      = 18'sd255;
  localparam logic signed [PosW-1:0]   RowMin      = 18'sd8;
  localparam logic signed [PosW-1:0]   RowMax      = 18'sd168;
  localparam logic [6:0]               QuarterTurn = 7'd64;

  typedef logic signed [TrigW-1:0] trig_t;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [NumW-1:0] n;    // numerator bits shift out, quotient bits shift in
  } div_lane_t;

  function automatic logic [7:0] quarter_sine(input logic [6:0] step);
    logic [7:0] s;
    case (step)
      7'd0:  s = 8'd0;    7'd1:  s = 8'd3;    7'd2:  s = 8'd6;    7'd3:  s = 8'd9;
      7'd4:  s = 8'd13;   7'd5:  s = 8'd16;   7'd6:  s = 8'd19;   7'd7:  s = 8'd22;
      7'd8:  s = 8'd25;   7'd9:  s = 8'd28;   7'd10: s = 8'd31;   7'd11: s = 8'd34;
      7'd12: s = 8'd37;   7'd13: s = 8'd40;   7'd14: s = 8'd43;   7'd15: s = 8'd46;
      7'd16: s = 8'd49;   7'd17: s = 8'd52;   7'd18: s = 8'd55;   7'd19: s = 8'd58;
      7'd20: s = 8'd60;   7'd21: s = 8'd63;   7'd22: s = 8'd66;   7'd23: s = 8'd68;
      7'd24: s = 8'd71;   7'd25: s = 8'd74;   7'd26: s = 8'd76;   7'd27: s = 8'd79;
      7'd28: s = 8'd81;   7'd29: s = 8'd84;   7'd30: s = 8'd86;   7'd31: s = 8'd88;
      7'd32: s = 8'd91;   7'd33: s = 8'd93;   7'd34: s = 8'd95;   7'd35: s = 8'd97;
      7'd36: s = 8'd99;   7'd37: s = 8'd101;  7'd38: s = 8'd103;  7'd39: s = 8'd105;
      7'd40: s = 8'd106;  7'd41: s = 8'd108;  7'd42: s = 8'd110;  7'd43: s = 8'd111;
      7'd44: s = 8'd113;  7'd45: s = 8'd114;  7'd46: s = 8'd116;  7'd47: s = 8'd117;
      7'd48: s = 8'd118;  7'd49: s = 8'd119;  7'd50: s = 8'd121;  7'd51: s = 8'd122;
      7'd52: s = 8'd122;  7'd53: s = 8'd123;  7'd54: s = 8'd124;  7'd55: s = 8'd125;
      7'd56: s = 8'd126;  7'd57: s = 8'd126;  7'd58: s = 8'd127;  7'd59: s = 8'd127;
      7'd60: s = 8'd127;  7'd61: s = 8'd128;  7'd62: s = 8'd128;  7'd63: s = 8'd128;
      7'd64: s = 8'd128;
      default: s = 8'd0;
    endcase
    return s;
  endfunction

  function automatic trig_t table_sin(input logic [AngleW-1:0] angle);
    logic [6:0] step;
    logic [7:0] mag;
    step = {1'b0, angle[5:0]};
    mag  = angle[6] ? quarter_sine(QuarterTurn - step) : quarter_sine(step);
    return angle[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  function automatic trig_t table_cos(input logic [AngleW-1:0] angle);
    return table_sin(angle + 8'd64);
  endfunction

  // divide by 128, truncating toward zero
  function automatic logic signed [RotW-1:0] trunc128(input logic signed [ProdW-1:0] s);
    logic signed [ProdW-1:0] a;
    a = s + (s[ProdW-1] ? 20'sd127 : 20'sd0);
    return a[RotW+6:7];
  endfunction

endpackage

@@ design/wireframe_segment_project_unit.sv @@
// wireframe segment projector
//
// input channel: a segment request (two signed 3d endpoints) is taken at a
// rising edge with start high and busy low. busy is held low: the pipeline
// takes one segment every cycle with no gaps.
// result channel: out_valid is high for exactly one cycle with both screen
// points and out_visible. a rejected segment shows visible low and all four
// screen fields zero. the receiver cannot stall, so nothing is held back.
// pipeline: nine register stages (input register, yaw, pitch, zoom multiply,
// four radix-2 divider stages of four bits each, output register).
// throughput: one segment per cycle; the divider stages set the depth.
// configuration: apb-style port, yaw at 0x0, pitch at 0x4, zoom at 0x8.
// write only while no request is in flight. sine and cosine are registered
// from the angle registers and follow a write in the next cycle.
// reset: synchronous active low; angles go to 22 and 12, zoom to 128, and
// every in-flight request is dropped.
module wireframe_segment_project_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [wsp_pkg::CoordW-1:0] in_start_x,
  input  logic signed [wsp_pkg::CoordW-1:0] in_start_y,
  input  logic signed [wsp_pkg::CoordW-1:0] in_start_z,
  input  logic signed [wsp_pkg::CoordW-1:0] in_end_x,
  input  logic signed [wsp_pkg::CoordW-1:0] in_end_y,
  input  logic signed [wsp_pkg::CoordW-1:0] in_end_z,
  output logic                             out_valid,
  output logic [wsp_pkg::ScreenW-1:0]      out_screen_start_x,
  output logic [wsp_pkg::ScreenW-1:0]      out_screen_start_y,
  output logic [wsp_pkg::ScreenW-1:0]      out_screen_end_x,
  output logic [wsp_pkg::ScreenW-1:0]      out_screen_end_y,
  output logic                             out_visible,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wsp_pkg::AddrW-1:0]        paddr,
  input  logic [wsp_pkg::DataW-1:0]        pwdata,
  output logic [wsp_pkg::DataW-1:0]        prdata,
  output logic                             pready
);

  localparam int Points    = wsp_pkg::Points;
  localparam int Lanes     = wsp_pkg::Lanes;
  localparam int DivStages = wsp_pkg::DivStages;

  // ---------------------------------------------------------------- config
  logic [wsp_pkg::AngleW-1:0] yaw_r, pitch_r;
  logic [wsp_pkg::ZoomW-1:0]  zoom_r;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_r   <= wsp_pkg::YawReset;
      pitch_r <= wsp_pkg::PitchReset;
      zoom_r  <= wsp_pkg::ZoomReset;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        wsp_pkg::RegYaw:   yaw_r   <= pwdata[wsp_pkg::AngleW-1:0];
        wsp_pkg::RegPitch: pitch_r <= pwdata[wsp_pkg::AngleW-1:0];
        wsp_pkg::RegZoom:  zoom_r  <= pwdata[wsp_pkg::ZoomW-1:0];
        default: ;  // unmapped register, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      wsp_pkg::RegYaw:   prdata = {{(wsp_pkg::DataW-wsp_pkg::AngleW){1'b0}}, yaw_r};
      wsp_pkg::RegPitch: prdata = {{(wsp_pkg::DataW-wsp_pkg::AngleW){1'b0}}, pitch_r};
      wsp_pkg::RegZoom:  prdata = {{(wsp_pkg::DataW-wsp_pkg::ZoomW){1'b0}}, zoom_r};
      default:           prdata = '0;
    endcase
  end

  // sine and cosine held in registers; the block itself does not ensure they are stable before a request uses them
  wsp_pkg::trig_t sy_r, cy_r, sp_r, cp_r;

  always_ff @(posedge clk) begin
    sy_r <= wsp_pkg::table_sin(yaw_r);
    cy_r <= wsp_pkg::table_cos(yaw_r);
    sp_r <= wsp_pkg::table_sin(pitch_r);
    cp_r <= wsp_pkg::table_cos(pitch_r);
  end

  // ---------------------------------------------------------- input stage
  logic                              v0_r;
  logic signed [wsp_pkg::CoordW-1:0] x0_r [Points];
  logic signed [wsp_pkg::CoordW-1:0] y0_r [Points];
  logic signed [wsp_pkg::CoordW-1:0] z0_r [Points];

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else        v0_r <= start & ~busy;
  end

  always_ff @(posedge clk) begin
    x0_r[0] <= in_start_x;  y0_r[0] <= in_start_y;  z0_r[0] <= in_start_z;
    x0_r[1] <= in_end_x;    y0_r[1] <= in_end_y;    z0_r[1] <= in_end_z;
  end

  // ------------------------------------------------------------ yaw stage
  logic                              va_r;
  logic signed [wsp_pkg::RotW-1:0]   ua_r [Points];
  logic signed [wsp_pkg::RotW-1:0]   wa_r [Points];
  logic signed [wsp_pkg::CoordW-1:0] ya_r [Points];
  logic signed [wsp_pkg::RotW-1:0]   ua_nxt [Points];
  logic signed [wsp_pkg::RotW-1:0]   wa_nxt [Points];

  always_comb begin
    logic signed [wsp_pkg::ProdW-1:0] su, sw;
    for (int p = 0; p < Points; p++) begin
      su = x0_r[p] * cy_r + z0_r[p] * sy_r;
      sw = z0_r[p] * cy_r - x0_r[p] * sy_r;
      ua_nxt[p] = wsp_pkg::trunc128(su);
      wa_nxt[p] = wsp_pkg::trunc128(sw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else        va_r <= v0_r;
  end

  always_ff @(posedge clk) begin
    ua_r <= ua_nxt;
    wa_r <= wa_nxt;
    ya_r <= y0_r;
  end

  // ---------------------------------------------------------- pitch stage
  logic                              vb_r;
  logic signed [wsp_pkg::RotW-1:0]   ub_r [Points];
  logic signed [wsp_pkg::RotW-1:0]   vb_nxt [Points];
  logic signed [wsp_pkg::RotW-1:0]   rv_r [Points];
  logic signed [wsp_pkg::DepthW-1:0] qb_nxt [Points];
  logic signed [wsp_pkg::DepthW-1:0] qb_r [Points];

  always_comb begin
    logic signed [wsp_pkg::ProdW-1:0] sv, sd;
    logic signed [wsp_pkg::RotW-1:0]  d;
    for (int p = 0; p < Points; p++) begin
      sv = ya_r[p] * cp_r - wa_r[p] * sp_r;
      sd = ya_r[p] * sp_r + wa_r[p] * cp_r;
      vb_nxt[p] = wsp_pkg::trunc128(sv);
      d         = wsp_pkg::trunc128(sd);
      qb_nxt[p] = wsp_pkg::DepthW'(d) + wsp_pkg::DepthOffset;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else        vb_r <= va_r;
  end

  always_ff @(posedge clk) begin
    ub_r <= ua_r;
    rv_r <= vb_nxt;
    qb_r <= qb_nxt;
  end

  // --------------------------------------------- zoom and depth-check stage
  // lane 2p is the column offset of endpoint p, lane 2p+1 its row offset
  wsp_pkg::div_lane_t              lane_c [Lanes];
  logic [Lanes-1:0]                neg_c;
  logic [Points-1:0]               fail_c;
  logic [wsp_pkg::DivW-1:0]        dvs_c [Points];

  always_comb begin
    logic signed [wsp_pkg::ProdW-1:0] pu, pv, au, av;
    for (int p = 0; p < Points; p++) begin
      pu = ub_r[p] * $signed({1'b0, zoom_r});
      pv = rv_r[p] * $signed({1'b0, zoom_r});
      au = pu[wsp_pkg::ProdW-1] ? -pu : pu;
      av = pv[wsp_pkg::ProdW-1] ? -pv : pv;
      lane_c[2*p].rem   = '0;
      lane_c[2*p].n     = au[wsp_pkg::NumW-1:0];
      lane_c[2*p+1].rem = '0;
      lane_c[2*p+1].n   = av[wsp_pkg::NumW-1:0];
      neg_c[2*p]        = pu[wsp_pkg::ProdW-1];
      neg_c[2*p+1]      = pv[wsp_pkg::ProdW-1];
      fail_c[p]         = qb_r[p] < wsp_pkg::DepthMin;
      dvs_c[p]          = qb_r[p][wsp_pkg::DivW-1:0];
    end
  end

  // -------------------------------------------------------- divider stages
  // restoring division, four quotient bits per stage, on magnitudes
  logic [DivStages:0]        dv_r;
  wsp_pkg::div_lane_t        lane_r [DivStages+1][Lanes];
  wsp_pkg::div_lane_t        lane_nxt [DivStages][Lanes];
  logic [Lanes-1:0]          neg_r  [DivStages+1];
  logic [Points-1:0]         fail_r [DivStages+1];
  logic [wsp_pkg::DivW-1:0]  dvs_r  [DivStages+1][Points];

  always_comb begin
    logic [wsp_pkg::RemW:0] sh;
    logic [wsp_pkg::RemW:0] dd;
    for (int k = 0; k < DivStages; k++) begin
      for (int l = 0; l < Lanes; l++) begin
        lane_nxt[k][l] = lane_r[k][l];
        dd = {1'b0, dvs_r[k][l>>1]};
        for (int b = 0; b < wsp_pkg::BitsPerStage; b++) begin
          sh = {lane_nxt[k][l].rem, lane_nxt[k][l].n[wsp_pkg::NumW-1]};
          lane_nxt[k][l].n = {lane_nxt[k][l].n[wsp_pkg::NumW-2:0], 1'b0};
          if (sh >= dd) begin
            sh = sh - dd;
            lane_nxt[k][l].n[0] = 1'b1;
          end
          lane_nxt[k][l].rem = sh[wsp_pkg::RemW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r <= '0;
    else        dv_r <= {dv_r[DivStages-1:0], vb_r};
  end

  always_ff @(posedge clk) begin
    lane_r[0] <= lane_c;
    neg_r[0]  <= neg_c;
    fail_r[0] <= fail_c;
    dvs_r[0]  <= dvs_c;
    for (int k = 0; k < DivStages; k++) begin
      lane_r[k+1] <= lane_nxt[k];
      neg_r[k+1]  <= neg_r[k];
      fail_r[k+1] <= fail_r[k];
      dvs_r[k+1]  <= dvs_r[k];
    end
  end

  // --------------------------------------------------- screen check, output
  logic signed [wsp_pkg::PosW-1:0] col_c [Points];
  logic signed [wsp_pkg::PosW-1:0] row_c [Points];
  logic [Points-1:0]               ok_c;
  logic                            vis_c;

  always_comb begin
    logic signed [wsp_pkg::PosW-1:0] qu, qv;
    for (int p = 0; p < Points; p++) begin
      qu = $signed({2'b00, lane_r[DivStages][2*p].n});
      qv = $signed({2'b00, lane_r[DivStages][2*p+1].n});
      if (neg_r[DivStages][2*p])   qu = -qu;
      if (neg_r[DivStages][2*p+1]) qv = -qv;
      col_c[p] = wsp_pkg::ColCentre + qu;
      row_c[p] = wsp_pkg::RowCentre - qv;
      ok_c[p]  = ~fail_r[DivStages][p]
               & (col_c[p] >= wsp_pkg::ColMin) & (col_c[p] <= wsp_pkg::ColMax)
               & (row_c[p] >= wsp_pkg::RowMin) & (row_c[p] <= wsp_pkg::RowMax);
    end
    vis_c = &ok_c;
  end

  logic                         out_valid_r, out_visible_r;
  logic [wsp_pkg::ScreenW-1:0]  sx0_r, sy0_r, sx1_r, sy1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= dv_r[DivStages];
  end

  // rejected segments report zero coordinates
  always_ff @(posedge clk) begin
    out_visible_r <= vis_c;
    sx0_r <= vis_c ? col_c[0][wsp_pkg::ScreenW-1:0] : '0;
    sy0_r <= vis_c ? row_c[0][wsp_pkg::ScreenW-1:0] : '0;
    sx1_r <= vis_c ? col_c[1][wsp_pkg::ScreenW-1:0] : '0;
    sy1_r <= vis_c ? row_c[1][wsp_pkg::ScreenW-1:0] : '0;
  end

  assign out_valid          = out_valid_r;
  assign out_visible        = out_visible_r;
  assign out_screen_start_x = sx0_r;
  assign out_screen_start_y = sy0_r;
  assign out_screen_end_x   = sx1_r;
  assign out_screen_end_y   = sy1_r;

  // ------------------------------------------------------------ assertions
  // every result traces back to an earlier request on start
  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 9))
    else $error("result without matching request");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_visible) |-> (out_screen_start_x == 8'd0 &&
      out_screen_start_y == 8'd0 && out_screen_end_x == 8'd0 && out_screen_end_y == 8'd0))
    else $error("rejected segment with nonzero coordinates");

  a_visible_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_visible) |-> (out_screen_start_y >= 8'd8 &&
      out_screen_start_y <= 8'd168 && out_screen_end_y >= 8'd8 && out_screen_end_y <= 8'd168))
    else $error("visible segment with row off screen");

endmodule
